// File: rtl/core/rhg_pkg.sv
// Shared types, constants and the arctangent table for the horizontal
// grid-line ray caster. No dependencies; every other file imports this one.
package rhg_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int CELL_SIZE    = 64;
    localparam int CELL_SHIFT   = FRAC_BITS + $clog2(CELL_SIZE);
    localparam int MAP_SIDE     = 64;
    localparam int MAP_BITS     = 6;
    localparam int MAP_DEPTH    = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_BITS    = 2 * MAP_BITS;
    localparam int POS_W        = 20;
    localparam int DIST_W       = 21;
    localparam int ANGLE_BITS   = 16;
    localparam int REM_BITS     = ANGLE_BITS - 2;
    localparam int CNT_W        = 7;
    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 45;
    localparam int SQRT_STEPS   = 21;
    localparam int FQ_DEPTH     = 4;
    localparam int RQ_DEPTH     = 2;

    localparam logic [DIST_W-1:0] DIST_MAX     = '1;
    localparam logic [44:0]       OFFSET_LIMIT = 45'd1 << 40;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_CAST  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } t_sign;

    typedef enum logic [1:0] {
        REG_PLAYER_X,
        REG_PLAYER_Y,
        REG_MAP_W,
        REG_MAP_H
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CS,
        ST_MUL,
        ST_DIV,
        ST_STEP_ADDR,
        ST_STEP_TEST,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [MAP_BITS-1:0] col;
        logic [MAP_BITS-1:0] row;
        logic                wall;
        logic                quad_odd;
        logic [REM_BITS-1:0] rem;
        t_sign               ss;
        t_sign               cs;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [DIST_W-1:0] distance;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic                 wdata;
        logic [ADDR_BITS-1:0] raddr;
    } t_map_req;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // arithmetic right shift that rounds toward zero
    function automatic logic signed [31:0] shr_tz(input logic signed [31:0] v,
                                                  input logic [4:0] s);
        logic [31:0] mag;
        logic [31:0] sh;
        mag = v[31] ? 32'(-v) : 32'(v);
        sh  = mag >> s;
        return v[31] ? -$signed(sh) : $signed(sh);
    endfunction

endpackage

// File: rtl/core/rhg_front.sv
// Front end: classifies incoming transactions (angle quadrant, sine and
// cosine signs) and queues them for the back end. Depends on rhg_pkg.
module rhg_front #(
    parameter int DEPTH = rhg_pkg::FQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              i_command,
    input  logic [rhg_pkg::MAP_BITS-1:0]      i_cell_col,
    input  logic [rhg_pkg::MAP_BITS-1:0]      i_cell_row,
    input  logic                              i_cell_is_wall,
    input  logic [rhg_pkg::ANGLE_BITS-1:0]    i_ray_angle,
    output logic                              o_full,
    output logic                              o_valid,
    output rhg_pkg::t_item                    o_item,
    input  logic                              i_pop
);
    import rhg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_count;
    t_item          cls;
    logic [1:0]     quad;
    logic           rz;

    always_comb begin
        quad         = i_ray_angle[ANGLE_BITS-1 -: 2];
        rz           = (i_ray_angle[REM_BITS-1:0] == '0);
        cls.cmd      = t_cmd'(i_command);
        cls.col      = i_cell_col;
        cls.row      = i_cell_row;
        cls.wall     = i_cell_is_wall;
        cls.quad_odd = quad[0];
        cls.rem      = i_ray_angle[REM_BITS-1:0];
        unique case (quad)
            2'd0: begin
                cls.ss = rz ? SGN_ZERO : SGN_POS;
                cls.cs = SGN_POS;
            end
            2'd1: begin
                cls.ss = SGN_POS;
                cls.cs = rz ? SGN_ZERO : SGN_NEG;
            end
            2'd2: begin
                cls.ss = rz ? SGN_ZERO : SGN_NEG;
                cls.cs = SGN_NEG;
            end
            default: begin
                cls.ss = SGN_NEG;
                cls.cs = rz ? SGN_ZERO : SGN_POS;
            end
        endcase
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

// File: rtl/core/rhg_map.sv
// One-bit wall map memory with a clearing sweep after reset.
// Depends on rhg_pkg.
module rhg_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rhg_pkg::t_map_req i_req,
    output logic              o_rd_data,
    output logic              o_busy
);
    import rhg_pkg::*;

    logic                 r_mem [MAP_DEPTH];
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_busy;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic                 wdata;

    assign we     = r_busy | i_req.we;
    assign waddr  = r_busy ? r_clr_addr : i_req.waddr;
    assign wdata  = r_busy ? 1'b0 : i_req.wdata;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        o_rd_data <= r_mem[i_req.raddr];
    end

endmodule

// File: rtl/core/rhg_back.sv
// Back end sequencer: CORDIC, shared long divider, grid walk against the
// map, and the distance square root. Depends on rhg_pkg.
module rhg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  rhg_pkg::t_item                i_item,
    output logic                          o_q_pop,
    input  logic [rhg_pkg::POS_W-1:0]     i_player_x,
    input  logic [rhg_pkg::POS_W-1:0]     i_player_y,
    input  logic [6:0]                    i_map_w,
    input  logic [6:0]                    i_map_h,
    output rhg_pkg::t_map_req             o_map_req,
    input  logic                          i_map_rd,
    output logic                          o_res_push,
    output rhg_pkg::t_result              o_res,
    input  logic                          i_res_full
);
    import rhg_pkg::*;

    t_back_state          r_state, n_state;
    logic                 map_we;

    logic                 r_quad_odd, r_phase, r_dyneg, r_rowok, r_hit;
    logic [REM_BITS-1:0]  r_rem;
    t_sign                r_ss, r_cs;
    logic signed [31:0]   r_x, r_y, r_z;
    logic [5:0]           r_cnt;
    logic [CNT_W-1:0]     r_n;
    logic [29:0]          r_cm, r_sm, r_rdiv;
    logic [14:0]          r_dymag;
    logic [44:0]          r_divd, r_quot;
    logic signed [42:0]   r_xi, r_xstep;
    logic signed [22:0]   r_yi;
    logic [POS_W-1:0]     r_hx, r_hy;
    logic [39:0]          r_acc;
    logic [41:0]          r_rad;
    logic [23:0]          r_srem;
    logic [DIST_W-1:0]    r_root;

    logic [6:0]           mw, mh, step_limit;
    logic [20:0]          wext, hext;
    logic signed [22:0]   yi0, dy0, ystep;
    logic [14:0]          dymag0;
    logic signed [31:0]   cx_sh, cy_sh, at_s;
    logic [29:0]          c_mag, s_mag;
    logic [44:0]          prod;
    logic [30:0]          div_part, div_sub;
    logic                 div_ge;
    logic [44:0]          quot_full;
    logic [40:0]          quot_lim, dxm;
    logic                 x_neg;
    logic                 in_x, in_y, step_out;
    logic [MAP_BITS-1:0]  yrow, row, col;
    logic                 row_neg;
    logic [POS_W-1:0]     m_a;
    logic [39:0]          sq;
    logic [23:0]          rem2, trial;
    logic                 sq_ge;

    always_comb begin
        mw         = (i_map_w > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : i_map_w;
        mh         = (i_map_h > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : i_map_h;
        step_limit = mh + 7'd2;
        wext       = {mw, 14'd0};
        hext       = {mh, 14'd0};

        // first horizontal grid line in the direction of travel
        yi0    = $signed({3'b000, i_player_y[POS_W-1:CELL_SHIFT], 14'd0})
                 + ((i_item.ss == SGN_POS) ? 23'sd16384 : 23'sd0);
        dy0    = yi0 - $signed({3'b000, i_player_y});
        dymag0 = dy0[22] ? 15'(-dy0) : 15'(dy0);

        // CORDIC micro-rotation
        cx_sh = shr_tz(r_y, r_cnt[4:0]);
        cy_sh = shr_tz(r_x, r_cnt[4:0]);
        at_s  = $signed({2'b00, atan_entry(r_cnt[4:0])});

        c_mag = r_x[31] ? '0 : r_x[29:0];
        s_mag = (r_y[31] || r_rem == '0) ? '0 : r_y[29:0];

        prod = r_dymag * r_cm;

        // restoring divider, one quotient bit a cycle
        div_part  = {r_rdiv, r_divd[44]};
        div_sub   = div_part - {1'b0, r_sm};
        div_ge    = (div_part >= {1'b0, r_sm});
        quot_full = {r_quot[43:0], div_ge};
        quot_lim  = (r_sm == '0 || quot_full > OFFSET_LIMIT) ? 41'(OFFSET_LIMIT)
                                                              : quot_full[40:0];
        dxm   = (r_cs == SGN_ZERO || r_dymag == '0) ? '0 : quot_lim;
        x_neg = r_dyneg ^ (r_ss == SGN_NEG) ^ (r_cs == SGN_NEG);

        in_x     = !r_xi[42] && (r_xi[41:0] < {21'd0, wext});
        in_y     = !r_yi[22] && (r_yi[21:0] < {1'b0, hext});
        step_out = (r_n == step_limit) || !in_x || !in_y;
        yrow     = r_yi[CELL_SHIFT +: MAP_BITS];
        col      = r_xi[CELL_SHIFT +: MAP_BITS];
        row_neg  = (r_ss == SGN_NEG) && (yrow == '0);
        row      = (r_ss == SGN_NEG) ? yrow - 1'b1 : yrow;
        ystep    = (r_ss == SGN_POS) ? 23'sd16384 : -23'sd16384;

        // one squarer shared between the two axes
        if (r_state == ST_SQ_Y) begin
            m_a = (r_hy >= i_player_y) ? r_hy - i_player_y : i_player_y - r_hy;
        end else begin
            m_a = (r_hx >= i_player_x) ? r_hx - i_player_x : i_player_x - r_hx;
        end
        sq = m_a * m_a;

        rem2  = {r_srem[21:0], r_rad[41:40]};
        trial = {1'b0, r_root, 2'b01};
        sq_ge = (rem2 >= trial);
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        map_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_item.cmd == CMD_WRITE) begin
                        map_we = 1'b1;
                    end else if (i_item.ss == SGN_ZERO) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC: begin
                if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                    n_state = ST_CS;
                end
            end
            ST_CS:  n_state = ST_MUL;
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = r_phase ? ST_STEP_ADDR : ST_MUL;
                end
            end
            ST_STEP_ADDR: n_state = step_out ? ST_EMIT : ST_STEP_TEST;
            ST_STEP_TEST: n_state = (r_rowok && i_map_rd) ? ST_SQ_X : ST_STEP_ADDR;
            ST_SQ_X: n_state = ST_SQ_Y;
            ST_SQ_Y: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_quad_odd <= i_item.quad_odd;
                r_rem      <= i_item.rem;
                r_ss       <= i_item.ss;
                r_cs       <= i_item.cs;
                r_x        <= 32'sd268435456;
                r_y        <= '0;
                r_z        <= $signed({2'b00, i_item.rem, 16'd0});
                r_cnt      <= '0;
                r_yi       <= yi0;
                r_dyneg    <= dy0[22];
                r_dymag    <= dymag0;
                r_hit      <= 1'b0;
            end
            ST_CORDIC: begin
                if (!r_z[31]) begin
                    r_x <= r_x - cx_sh;
                    r_y <= r_y + cy_sh;
                    r_z <= r_z - at_s;
                end else begin
                    r_x <= r_x + cx_sh;
                    r_y <= r_y - cy_sh;
                    r_z <= r_z + at_s;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            ST_CS: begin
                r_cm    <= r_quad_odd ? s_mag : c_mag;
                r_sm    <= r_quad_odd ? c_mag : s_mag;
                r_phase <= 1'b0;
            end
            ST_MUL: begin
                r_divd <= r_phase ? {1'b0, r_cm, 14'd0} : prod;
                r_rdiv <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
            end
            ST_DIV: begin
                r_rdiv <= div_ge ? div_sub[29:0] : div_part[29:0];
                r_divd <= {r_divd[43:0], 1'b0};
                r_quot <= quot_full;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    if (!r_phase) begin
                        r_xi    <= x_neg ? $signed({23'd0, i_player_x}) - $signed({2'b00, dxm})
                                         : $signed({23'd0, i_player_x}) + $signed({2'b00, dxm});
                        r_phase <= 1'b1;
                    end else begin
                        r_xstep <= (r_cs == SGN_NEG)  ? -$signed({2'b00, quot_lim}) :
                                   (r_cs == SGN_ZERO) ? 43'sd0 : $signed({2'b00, quot_lim});
                        r_n     <= '0;
                    end
                end
            end
            ST_STEP_ADDR: r_rowok <= !row_neg;
            ST_STEP_TEST: begin
                if (r_rowok && i_map_rd) begin
                    r_hit <= 1'b1;
                    r_hx  <= r_xi[POS_W-1:0];
                    r_hy  <= r_yi[POS_W-1:0];
                end else begin
                    r_xi <= r_xi + r_xstep;
                    r_yi <= r_yi + ystep;
                    r_n  <= r_n + 1'b1;
                end
            end
            ST_SQ_X: r_acc <= sq;
            ST_SQ_Y: begin
                r_rad  <= {1'b0, {1'b0, r_acc} + {1'b0, sq}};
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            ST_SQRT: begin
                r_srem <= sq_ge ? rem2 - trial : rem2;
                r_root <= {r_root[DIST_W-2:0], sq_ge};
                r_rad  <= {r_rad[39:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_map_req.we    = map_we;
    assign o_map_req.waddr = {i_item.row, i_item.col};
    assign o_map_req.wdata = i_item.wall;
    assign o_map_req.raddr = {row, col};

    assign o_res.hit      = r_hit;
    assign o_res.x        = r_hit ? r_hx : '0;
    assign o_res.y        = r_hit ? r_hy : '0;
    assign o_res.distance = r_hit ? r_root : DIST_MAX;

endmodule

// File: rtl/core/rhg_resq.sv
// Result queue between the back end and the output port.
// Depends on rhg_pkg.
module rhg_resq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rhg_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    output rhg_pkg::t_result o_head,
    input  logic             i_pop
);
    import rhg_pkg::*;

    localparam int PW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    t_result       r_mem [RQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(RQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

endmodule

// File: rtl/core/ray_horizontal_gridline_hit.sv
// Top level of the horizontal grid-line ray caster: configuration registers,
// front/back split and result queue. Depends on rhg_pkg and all rhg_* modules.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  item in   | push / full          | i_command, i_cell_col/row, i_cell_is_wall,
//            |                      | i_ray_angle
//  result    | empty / pop          | o_wall_hit, o_hit_x, o_hit_y, o_hit_distance
//  config    | psel/penable/pready  | paddr, pwdata, prdata (4 regs, 4-byte stride)
//
// In the back end a map write transaction retires without leaving idle, and a
// horizontal ray goes straight to the result. Any other cast runs 28 CORDIC
// steps, two passes of the shared bit-serial divider, then the walk with one
// map read per grid line tested (at most map height + 2), and on a hit the
// squaring states ST_SQ_X and ST_SQ_Y and 21 square-root steps.
// Reset is synchronous; after it the map is swept clear, one cell a cycle,
// with full held high (configuration still works).
// Front queue and result queue let either side stall independently.
module ray_horizontal_gridline_hit #(
    parameter int FRONT_DEPTH = rhg_pkg::FQ_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              push,
    output logic                              full,
    input  logic                              i_command,
    input  logic [rhg_pkg::MAP_BITS-1:0]      i_cell_col,
    input  logic [rhg_pkg::MAP_BITS-1:0]      i_cell_row,
    input  logic                              i_cell_is_wall,
    input  logic [rhg_pkg::ANGLE_BITS-1:0]    i_ray_angle,
    // result channel
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_wall_hit,
    output logic [rhg_pkg::POS_W-1:0]         o_hit_x,
    output logic [rhg_pkg::POS_W-1:0]         o_hit_y,
    output logic [rhg_pkg::DIST_W-1:0]        o_hit_distance,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rhg_pkg::*;

    logic [POS_W-1:0] r_player_x, r_player_y;
    logic [6:0]       r_map_w, r_map_h;
    logic             cfg_wr;
    t_reg_idx         reg_idx;

    logic             front_full, front_push, q_valid, q_pop;
    t_item            q_item;
    t_map_req         map_req;
    logic             map_rd, map_busy;
    logic             res_push, res_full;
    t_result          res_in, res_head;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
            r_map_w    <= 7'(MAP_SIDE);
            r_map_h    <= 7'(MAP_SIDE);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PLAYER_X: r_player_x <= pwdata[POS_W-1:0];
                REG_PLAYER_Y: r_player_y <= pwdata[POS_W-1:0];
                REG_MAP_W:    r_map_w    <= pwdata[6:0];
                REG_MAP_H:    r_map_h    <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PLAYER_X: prdata = {12'd0, r_player_x};
            REG_PLAYER_Y: prdata = {12'd0, r_player_y};
            REG_MAP_W:    prdata = {25'd0, r_map_w};
            REG_MAP_H:    prdata = {25'd0, r_map_h};
        endcase
    end

    // no items while the map is being swept clear
    assign full       = front_full | map_busy;
    assign front_push = push & ~full;

    rhg_front #(
        .DEPTH(FRONT_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (front_push),
        .i_command      (i_command),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_is_wall (i_cell_is_wall),
        .i_ray_angle    (i_ray_angle),
        .o_full         (front_full),
        .o_valid        (q_valid),
        .o_item         (q_item),
        .i_pop          (q_pop)
    );

    rhg_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd),
        .o_busy    (map_busy)
    );

    rhg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_q_pop    (q_pop),
        .i_player_x (r_player_x),
        .i_player_y (r_player_y),
        .i_map_w    (r_map_w),
        .i_map_h    (r_map_h),
        .o_map_req  (map_req),
        .i_map_rd   (map_rd),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    rhg_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .o_head  (res_head),
        .i_pop   (pop)
    );

    assign o_wall_hit     = res_head.hit;
    assign o_hit_x        = res_head.x;
    assign o_hit_y        = res_head.y;
    assign o_hit_distance = res_head.distance;

    // clearing sweep must hold off new transactions
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_busy |-> full)
        else $error("item channel open during map clear");

    // back end only pushes into a result queue with room
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // a miss carries zero position and saturated distance
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_wall_hit) |-> (o_hit_distance == DIST_MAX && o_hit_x == '0
                                     && o_hit_y == '0))
        else $error("miss result with stray fields");

    // a hit lies inside the map, so its distance never saturates
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_wall_hit) |-> (o_hit_distance != DIST_MAX))
        else $error("hit result with saturated distance");

endmodule

// File: tb/ray_horizontal_gridline_hit_test.sv
// Self-checking testbench for the horizontal grid-line ray caster.
// Needs rhg_pkg and the block ray_horizontal_gridline_hit; nothing else.
module ray_horizontal_gridline_hit_test;
    import rhg_pkg::*;

    localparam int     SETTLE_CYCLES = 400;    // longest cast plus margin
    localparam int     HOLD_CYCLES   = 2000;   // long receiver hold-off
    localparam int     STALL_LIMIT   = 20000;  // covers the map clearing sweep
    localparam longint CELL_Q        = longint'(CELL_SIZE) << FRAC_BITS;
    localparam longint OFS_LIMIT     = longint'(1) << 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_command = 1'b0;
    logic [MAP_BITS-1:0]   i_cell_col = '0;
    logic [MAP_BITS-1:0]   i_cell_row = '0;
    logic                  i_cell_is_wall = 1'b0;
    logic [ANGLE_BITS-1:0] i_ray_angle = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_wall_hit;
    logic [POS_W-1:0]      o_hit_x;
    logic [POS_W-1:0]      o_hit_y;
    logic [DIST_W-1:0]     o_hit_distance;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    ray_horizontal_gridline_hit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the block: wall bits, player position and map extent
    logic   wall_bits [MAP_DEPTH];
    longint pos_x, pos_y, cols_used, rows_used;

    t_result hits_due [$];   // expected cast outcomes, oldest first
    int      fail_count = 0;
    bit      hold_req   = 1'b0;
    int      idle_cycles = 0;

    const longint atan_tab [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    function automatic longint shift_tz(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    // x offset |num/den| * mag, saturating when the sine is zero or the offset too large
    function automatic longint scaled_offset(longint mag, longint num, longint den);
        longint unsigned quo;
        if (den <= 0) return OFS_LIMIT;
        quo = (longint'(mag) * longint'(num)) / den;
        return quo > OFS_LIMIT ? OFS_LIMIT : longint'(quo);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag31(longint v);
        longint unsigned a;
        a = v < 0 ? -v : v;
        return a > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : a;
    endfunction

    function automatic logic [POS_W-1:0] clip_pos(longint v);
        if (v < 0) return '0;
        return v > 1048575 ? '1 : v[POS_W-1:0];
    endfunction

    // Work out the outcome of one cast from the shadow state
    function automatic t_result cast_outcome(logic [ANGLE_BITS-1:0] ang);
        t_result res;
        int      quad, rem, ss, cs, k;
        longint  cx, cy, cz, ddx, ddy, cosm, sinm;
        longint  mw, mh, wext, hext, yi, dy, dxm, xi, xstep, ystep, col, row;
        longint  hx, hy;
        longint unsigned ax, ay, d;
        bit      hit;

        quad = ang >> (ANGLE_BITS - 2);
        rem  = ang & ((1 << (ANGLE_BITS - 2)) - 1);
        case (quad)
            0:       begin ss = rem == 0 ? 0 : 1;  cs = 1; end
            1:       begin ss = 1; cs = rem == 0 ? 0 : -1; end
            2:       begin ss = rem == 0 ? 0 : -1; cs = -1; end
            default: begin ss = -1; cs = rem == 0 ? 0 : 1; end
        endcase

        // unscaled rotation; only the cos/sin ratio is used
        cx = longint'(1) << 28;
        cy = 0;
        cz = longint'(rem) << (32 - ANGLE_BITS);
        for (k = 0; k < CORDIC_STEPS; k++) begin
            ddx = shift_tz(cy, k);
            ddy = shift_tz(cx, k);
            if (cz >= 0) begin
                cx -= ddx; cy += ddy; cz -= atan_tab[k];
            end else begin
                cx += ddx; cy -= ddy; cz += atan_tab[k];
            end
        end
        if (rem == 0) cy = 0;
        if (cx < 0) cx = 0;
        if (cy < 0) cy = 0;
        if (quad % 2 == 1) begin
            cosm = cy; sinm = cx;
        end else begin
            cosm = cx; sinm = cy;
        end

        mw   = cols_used > MAP_SIDE ? MAP_SIDE : cols_used;
        mh   = rows_used > MAP_SIDE ? MAP_SIDE : rows_used;
        wext = mw * CELL_Q;
        hext = mh * CELL_Q;
        hit  = 1'b0;
        hx   = 0;
        hy   = 0;

        if (ss != 0) begin
            yi = (pos_y / CELL_Q) * CELL_Q;
            if (ss > 0) yi += CELL_Q;
            dy  = yi - pos_y;
            dxm = scaled_offset(dy < 0 ? -dy : dy, cosm, sinm);
            if (cs == 0 || dy == 0) dxm = 0;
            xi = pos_x + (((dy < 0 ? -1 : 1) * ss * cs) < 0 ? -dxm : dxm);
            xstep = scaled_offset(CELL_Q, cosm, sinm);
            if (cs < 0) xstep = -xstep;
            else if (cs == 0) xstep = 0;
            ystep = ss > 0 ? CELL_Q : -CELL_Q;
            for (longint n = 0; n < mh + 2; n++) begin
                if (xi < 0 || xi >= wext || yi < 0 || yi >= hext) break;
                col = xi / CELL_Q;
                row = yi / CELL_Q;
                // upward rays test the cell above the line
                if (ss < 0) row -= 1;
                if (row >= 0 && row < mh && col < mw && wall_bits[row * MAP_SIDE + col]) begin
                    hit = 1'b1; hx = xi; hy = yi;
                    break;
                end
                xi += xstep;
                yi += ystep;
            end
        end

        if (hit) begin
            ax = mag31(hx - pos_x);
            ay = mag31(hy - pos_y);
            d  = floor_root(ax * ax + ay * ay);
            res.hit      = 1'b1;
            res.x        = clip_pos(hx);
            res.y        = clip_pos(hy);
            res.distance = d > DIST_MAX ? DIST_MAX : d[DIST_W-1:0];
        end else begin
            res.hit      = 1'b0;
            res.x        = '0;
            res.y        = '0;
            res.distance = DIST_MAX;
        end
        return res;
    endfunction

    // One input transaction; push is left high so back-to-back items need no dip
    task automatic send_item(t_cmd cmd, int col, int row, bit wall, int ang);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;   // bursts without gaps
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push           <= 1'b1;
        i_command      <= cmd;
        i_cell_col     <= MAP_BITS'(col);
        i_cell_row     <= MAP_BITS'(row);
        i_cell_is_wall <= wall;
        i_ray_angle    <= ANGLE_BITS'(ang);
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (cmd == CMD_WRITE) wall_bits[row * MAP_SIDE + col] = wall;
        else hits_due.push_back(cast_outcome(ang[ANGLE_BITS-1:0]));
        @(negedge i_clk);
    endtask

    task automatic write_cell(int col, int row, bit wall);
        send_item(CMD_WRITE, col, row, wall, $urandom_range(0, 65535));
    endtask

    task automatic cast_ray(int ang);
        send_item(CMD_CAST, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), ang);
    endtask

    // Stop offering, wait until every cast has reported, then let a trailing
    // map write or cast finish inside the block
    task automatic settle();
        push <= 1'b0;
        while (hits_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write: setup phase, access phase, then idle
    task automatic reg_write(t_reg_idx idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_PLAYER_X: pos_x     = value & 32'hF_FFFF;
            REG_PLAYER_Y: pos_y     = value & 32'hF_FFFF;
            REG_MAP_W:    cols_used = value & 32'h7F;
            REG_MAP_H:    rows_used = value & 32'h7F;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_scene(int unsigned px, int unsigned py, int mw, int mh);
        reg_write(REG_PLAYER_X, px);
        reg_write(REG_PLAYER_Y, py);
        reg_write(REG_MAP_W, mw);
        reg_write(REG_MAP_H, mh);
    endtask

    // Corners, the four axis angles, their neighbours, three diagonals and the degenerate maps
    task automatic test_directed();
        const int axis_angles [10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h0001,
                                       16'hFFFF, 16'h3FFF, 16'h2000, 16'hA000, 16'h6000};
        write_cell(0, 0, 1'b1);
        write_cell(63, 63, 1'b1);
        write_cell(63, 0, 1'b1);
        write_cell(0, 63, 1'b1);
        write_cell(20, 20, 1'b1);
        write_cell(20, 20, 1'b0);   // overwrite back to open
        settle();
        set_scene(32 * CELL_Q + 100, 32 * CELL_Q + 57, 64, 64);
        foreach (axis_angles[k]) cast_ray(axis_angles[k]);
        settle();
        // upward ray from the top row: the row above the map is never wall
        set_scene(5 * CELL_Q, 12, 64, 64);
        cast_ray(16'hC000);
        cast_ray(16'hD123);
        settle();
        // nothing lies inside a zero-sized map
        set_scene(0, 0, 0, 127);
        cast_ray(16'h4000);
        cast_ray(16'h1234);
        settle();
        // oversized extent acts as the full map; player at the far corner
        set_scene(32'hF_FFFF, 32'hF_FFFF, 127, 0);
        cast_ray(16'hC000);
        settle();
        set_scene(32'hF_FFFF, 32'hF_FFFF, 127, 100);
        cast_ray(16'hE000);
        cast_ray(16'hC001);
        settle();
    endtask

    // Random map contents and random rays under one random scene
    task automatic random_phase(int n_items, int wall_pct, bit anywhere);
        int mw, mh;
        settle();
        mw = $urandom_range(1, 64);
        mh = $urandom_range(1, 64);
        if ($urandom_range(0, 4) == 0) mw = $urandom_range(0, 127);
        if ($urandom_range(0, 4) == 0) mh = $urandom_range(0, 127);
        if (anywhere)
            set_scene($urandom_range(0, 32'hF_FFFF), $urandom_range(0, 32'hF_FFFF), mw, mh);
        else
            set_scene($urandom_range(0, (mw > 64 ? 64 : mw) * CELL_Q),
                      $urandom_range(0, (mh > 64 ? 64 : mh) * CELL_Q), mw, mh);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 35)
                write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 99) < wall_pct);
            else
                cast_ray($urandom_range(0, 65535));
        end
    endtask

    task automatic test_random_rays();
        for (int p = 0; p < 9; p++) random_phase(100, 20 + 8 * p, p == 4);
    endtask

    // Receiver holds off while casts keep arriving: queues fill, full rises
    task automatic test_backpressure();
        settle();
        set_scene(20 * CELL_Q, 40 * CELL_Q + 3, 64, 64);
        hold_req = 1'b1;
        repeat (40) cast_ray($urandom_range(0, 65535));
    endtask

    // Sender stops until everything is back, then resumes
    task automatic test_sender_pause();
        repeat (30) cast_ray($urandom_range(0, 65535));
        push <= 1'b0;
        while (hits_due.size() != 0) @(negedge i_clk);
        repeat (30) cast_ray($urandom_range(0, 65535));
    endtask

    // Receiver: random gap before each result, one long hold-off on request
    initial begin
        int w;
        @(negedge i_clk);
        forever begin
            w = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (w > 0) begin
                pop <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Result checker: every accepted transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (hits_due.size() == 0) begin
                $display("%0t: unexpected result hit=%0b x=%0d y=%0d dist=%0d", $time,
                         o_wall_hit, o_hit_x, o_hit_y, o_hit_distance);
                fail_count++;
            end else begin
                want = hits_due.pop_front();
                if (o_wall_hit !== want.hit) begin
                    $display("%0t: wall_hit expected %0b actual %0b", $time, want.hit, o_wall_hit);
                    fail_count++;
                end
                if (o_hit_x !== want.x) begin
                    $display("%0t: hit_x expected %0d actual %0d", $time, want.x, o_hit_x);
                    fail_count++;
                end
                if (o_hit_y !== want.y) begin
                    $display("%0t: hit_y expected %0d actual %0d", $time, want.y, o_hit_y);
                    fail_count++;
                end
                if (o_hit_distance !== want.distance) begin
                    $display("%0t: hit_distance expected %0d actual %0d", $time,
                             want.distance, o_hit_distance);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        foreach (wall_bits[k]) wall_bits[k] = 1'b0;
        pos_x     = 0;
        pos_y     = 0;
        cols_used = 64;
        rows_used = 64;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_rays();
        test_backpressure();
        test_sender_pause();

        settle();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rhg_pkg.sv
rtl/core/rhg_front.sv
rtl/core/rhg_map.sv
rtl/core/rhg_back.sv
rtl/core/rhg_resq.sv
rtl/core/ray_horizontal_gridline_hit.sv
tb/ray_horizontal_gridline_hit_test.sv
